@@ rtl/fcmb_pkg.sv @@
// Package: shared types, constants and helpers for the frame count / MSF BCD converter.
`timescale 1ns / 1ps

package fcmb_pkg;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e;

  localparam int unsigned FRAME_COUNT_W   = 20;
  localparam int unsigned DECODED_COUNT_W = 21;
  localparam int unsigned BCD_W           = 8;

  localparam int unsigned LEAD_IN_BIAS    = 150;
  localparam int unsigned FRAMES_PER_SEC  = 75;
  localparam int unsigned SECS_PER_MIN    = 60;

  // Reciprocals for exact division of the narrow values used here.
  localparam logic [31:0] RECIP_75 = 32'h1B4E81B5;
  localparam int unsigned SHIFT_75 = 35;
  localparam logic [31:0] RECIP_60 = 32'h88888889;
  localparam int unsigned SHIFT_60 = 37;
  localparam logic [31:0] RECIP_10 = 32'h66666667;
  localparam int unsigned SHIFT_10 = 34;

  typedef logic signed [FRAME_COUNT_W-1:0]   frame_count_t;
  typedef logic signed [DECODED_COUNT_W-1:0] decoded_count_t;
  typedef logic        [BCD_W-1:0]           bcd_t;

  // Packed byte read as high nibble * 10 + low nibble, nibbles at face value.
  function automatic logic [7:0] unpack_bcd(input bcd_t b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'b0000, b[7:4]};
    lo = {4'b0000, b[3:0]};
    return 8'((hi << 3) + (hi << 1) + lo);
  endfunction

endpackage

@@ rtl/fcmb_in_if.sv @@
// Interface: input item channel of the converter.
`timescale 1ns / 1ps

interface fcmb_in_if;
  logic                  valid;
  logic                  ready;
  fcmb_pkg::cmd_e        command;
  fcmb_pkg::frame_count_t frame_count;
  fcmb_pkg::bcd_t        minute_bcd_in;
  fcmb_pkg::bcd_t        second_bcd_in;
  fcmb_pkg::bcd_t        frame_bcd_in;

  modport source (
    output valid, command, frame_count, minute_bcd_in, second_bcd_in, frame_bcd_in,
    input  ready
  );
  modport sink (
    input  valid, command, frame_count, minute_bcd_in, second_bcd_in, frame_bcd_in,
    output ready
  );
endinterface

@@ rtl/fcmb_out_if.sv @@
// Interface: result item channel of the converter.
`timescale 1ns / 1ps

interface fcmb_out_if;
  logic                     valid;
  logic                     ready;
  fcmb_pkg::decoded_count_t decoded_count;
  fcmb_pkg::bcd_t           minute_bcd_out;
  fcmb_pkg::bcd_t           second_bcd_out;
  fcmb_pkg::bcd_t           frame_bcd_out;

  modport source (
    output valid, decoded_count, minute_bcd_out, second_bcd_out, frame_bcd_out,
    input  ready
  );
  modport sink (
    input  valid, decoded_count, minute_bcd_out, second_bcd_out, frame_bcd_out,
    output ready
  );
endinterface

@@ rtl/frame_count_msf_bcd_convert_core.sv @@
// Top level: six-stage pipelined frame count <-> packed BCD MSF converter.
//
//   channel | dir | handshake    | payload
//   --------+-----+--------------+----------------------------------------------
//   in_i    | in  | valid/ready  | command, frame_count, minute/second/frame_bcd_in
//   out_o   | out | valid/ready  | decoded_count, minute/second/frame_bcd_out
//
// One item per cycle while out_o is not stalled; the constant-reciprocal multiplies
// (/75, /60, then /10 for each BCD digit) each have a register after them in the pipe.
// Each stage loads when it is empty or the stage after it moves, so bubbles collapse.
// Reset clears only the stage valid bits; payload registers carry no reset.
// A stalled output holds the whole occupied tail of the pipe without loss or repeat.
`timescale 1ns / 1ps

module frame_count_msf_bcd_convert_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  fcmb_in_if.sink           in_i,
  fcmb_out_if.source        out_o
);

  localparam int unsigned NSTAGE = 6;
  localparam int unsigned XW     = 20;  // |count + bias|, at most 524437
  localparam int unsigned TSW    = 13;  // total seconds
  localparam int unsigned MINW   = 7;
  localparam int unsigned SECW   = 6;
  localparam int unsigned FRMW   = 7;
  localparam int unsigned TENW   = 4;
  localparam int unsigned DTW    = 14;  // decode: 60*min + sec

  // ---------------------------------------------------------------- handshake
  logic [NSTAGE-1:0] valid_q;
  logic [NSTAGE-1:0] valid_d;
  logic [NSTAGE-1:0] load;

  always_comb begin
    load[NSTAGE-1] = !valid_q[NSTAGE-1] || out_o.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
    valid_d = valid_q;
    if (load[0]) begin
      valid_d[0] = in_i.valid;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (load[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_i.ready  = load[0];
  assign out_o.valid = valid_q[NSTAGE-1];

  // ---------------------------------------------------------------- stage 1
  // Bias, take magnitude; unpack the BCD bytes.
  logic signed [XW:0] s1_x;
  logic [XW:0]        s1_xneg;
  logic [XW-1:0]      s1_xabs_d;
  logic               s1_neg_d;

  fcmb_pkg::cmd_e s1_cmd_q;
  logic [XW-1:0]  s1_xabs_q;
  logic           s1_neg_q;
  logic [7:0]     s1_min_q, s1_sec_q, s1_frm_q;

  always_comb begin
    s1_x      = {in_i.frame_count[XW-1], in_i.frame_count}
                + (XW+1)'(fcmb_pkg::LEAD_IN_BIAS);
    s1_xneg   = -s1_x;
    s1_neg_d  = s1_x[XW];
    s1_xabs_d = s1_neg_d ? s1_xneg[XW-1:0] : s1_x[XW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      s1_cmd_q  <= in_i.command;
      s1_xabs_q <= s1_xabs_d;
      s1_neg_q  <= s1_neg_d;
      s1_min_q  <= fcmb_pkg::unpack_bcd(in_i.minute_bcd_in);
      s1_sec_q  <= fcmb_pkg::unpack_bcd(in_i.second_bcd_in);
      s1_frm_q  <= fcmb_pkg::unpack_bcd(in_i.frame_bcd_in);
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Total seconds = |x| / 75; decode 60*min + sec.
  logic [XW+31:0] s2_p75;
  logic [TSW-1:0] s2_ts_d;
  logic [DTW-1:0] s2_dt_d;

  fcmb_pkg::cmd_e s2_cmd_q;
  logic [XW-1:0]  s2_xabs_q;
  logic           s2_neg_q;
  logic [TSW-1:0] s2_ts_q;
  logic [DTW-1:0] s2_dt_q;
  logic [7:0]     s2_frm_q;

  always_comb begin
    s2_p75  = (XW+32)'(s1_xabs_q) * (XW+32)'(fcmb_pkg::RECIP_75);
    s2_ts_d = s2_p75[fcmb_pkg::SHIFT_75 +: TSW];
    s2_dt_d = DTW'(s1_min_q) * DTW'(fcmb_pkg::SECS_PER_MIN) + DTW'(s1_sec_q);
  end

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      s2_cmd_q  <= s1_cmd_q;
      s2_xabs_q <= s1_xabs_q;
      s2_neg_q  <= s1_neg_q;
      s2_ts_q   <= s2_ts_d;
      s2_dt_q   <= s2_dt_d;
      s2_frm_q  <= s1_frm_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Minutes = ts / 60, frames = |x| - 75*ts; finish the decode sum.
  logic [TSW+31:0]                s3_p60;
  logic [MINW-1:0]                s3_min_d;
  logic [XW-1:0]                  s3_ts75;
  logic [XW-1:0]                  s3_frmw;
  logic [FRMW-1:0]                s3_frm_d;
  logic [fcmb_pkg::DECODED_COUNT_W-1:0] s3_val_d;

  fcmb_pkg::cmd_e           s3_cmd_q;
  logic                     s3_neg_q;
  logic [TSW-1:0]           s3_ts_q;
  logic [MINW-1:0]          s3_min_q;
  logic [FRMW-1:0]          s3_frm_q;
  fcmb_pkg::decoded_count_t s3_val_q;

  always_comb begin
    s3_p60   = (TSW+32)'(s2_ts_q) * (TSW+32)'(fcmb_pkg::RECIP_60);
    s3_min_d = s3_p60[fcmb_pkg::SHIFT_60 +: MINW];
    s3_ts75  = XW'(s2_ts_q) * XW'(fcmb_pkg::FRAMES_PER_SEC);
    s3_frmw  = s2_xabs_q - s3_ts75;
    s3_frm_d = s3_frmw[FRMW-1:0];
    s3_val_d = fcmb_pkg::DECODED_COUNT_W'(s2_dt_q)
               * fcmb_pkg::DECODED_COUNT_W'(fcmb_pkg::FRAMES_PER_SEC)
               + fcmb_pkg::DECODED_COUNT_W'(s2_frm_q)
               - fcmb_pkg::DECODED_COUNT_W'(fcmb_pkg::LEAD_IN_BIAS);
  end

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      s3_cmd_q <= s2_cmd_q;
      s3_neg_q <= s2_neg_q;
      s3_ts_q  <= s2_ts_q;
      s3_min_q <= s3_min_d;
      s3_frm_q <= s3_frm_d;
      s3_val_q <= s3_val_d;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Seconds = ts - 60*min; tens digits of minutes and frames.
  logic [TSW-1:0]   s4_secw;
  logic [SECW-1:0]  s4_sec_d;
  logic [MINW+31:0] s4_pmin;
  logic [FRMW+31:0] s4_pfrm;
  logic [TENW-1:0]  s4_min_ten_d, s4_frm_ten_d;

  fcmb_pkg::cmd_e           s4_cmd_q;
  logic                     s4_neg_q;
  logic [SECW-1:0]          s4_sec_q;
  logic [MINW-1:0]          s4_min_q;
  logic [FRMW-1:0]          s4_frm_q;
  logic [TENW-1:0]          s4_min_ten_q, s4_frm_ten_q;
  fcmb_pkg::decoded_count_t s4_val_q;

  always_comb begin
    s4_secw      = s3_ts_q - TSW'(s3_min_q) * TSW'(fcmb_pkg::SECS_PER_MIN);
    s4_sec_d     = s4_secw[SECW-1:0];
    s4_pmin      = (MINW+32)'(s3_min_q) * (MINW+32)'(fcmb_pkg::RECIP_10);
    s4_pfrm      = (FRMW+32)'(s3_frm_q) * (FRMW+32)'(fcmb_pkg::RECIP_10);
    s4_min_ten_d = s4_pmin[fcmb_pkg::SHIFT_10 +: TENW];
    s4_frm_ten_d = s4_pfrm[fcmb_pkg::SHIFT_10 +: TENW];
  end

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      s4_cmd_q     <= s3_cmd_q;
      s4_neg_q     <= s3_neg_q;
      s4_sec_q     <= s4_sec_d;
      s4_min_q     <= s3_min_q;
      s4_frm_q     <= s3_frm_q;
      s4_min_ten_q <= s4_min_ten_d;
      s4_frm_ten_q <= s4_frm_ten_d;
      s4_val_q     <= s3_val_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Pack minutes and frames; tens digit of seconds.
  logic [MINW-1:0]  s5_min_unit;
  logic [FRMW-1:0]  s5_frm_unit;
  logic [SECW+31:0] s5_psec;
  logic [TENW-1:0]  s5_sec_ten_d;

  fcmb_pkg::cmd_e           s5_cmd_q;
  logic                     s5_neg_q;
  logic [SECW-1:0]          s5_sec_q;
  logic [TENW-1:0]          s5_sec_ten_q;
  fcmb_pkg::bcd_t           s5_min_bcd_q, s5_frm_bcd_q;
  fcmb_pkg::decoded_count_t s5_val_q;

  always_comb begin
    s5_min_unit  = s4_min_q - MINW'(s4_min_ten_q) * MINW'(10);
    s5_frm_unit  = s4_frm_q - FRMW'(s4_frm_ten_q) * FRMW'(10);
    s5_psec      = (SECW+32)'(s4_sec_q) * (SECW+32)'(fcmb_pkg::RECIP_10);
    s5_sec_ten_d = s5_psec[fcmb_pkg::SHIFT_10 +: TENW];
  end

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      s5_cmd_q     <= s4_cmd_q;
      s5_neg_q     <= s4_neg_q;
      s5_sec_q     <= s4_sec_q;
      s5_sec_ten_q <= s5_sec_ten_d;
      s5_min_bcd_q <= {s4_min_ten_q, s5_min_unit[3:0]};
      s5_frm_bcd_q <= {s4_frm_ten_q, s5_frm_unit[3:0]};
      s5_val_q     <= s4_val_q;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // Pack seconds, apply the sign of the biased count, zero the unused fields.
  logic [SECW-1:0]          s6_sec_unit;
  fcmb_pkg::bcd_t           s6_sec_bcd;
  fcmb_pkg::bcd_t           s6_min_d, s6_sec_d, s6_frm_d;
  fcmb_pkg::decoded_count_t s6_val_d;

  fcmb_pkg::decoded_count_t s6_val_q;
  fcmb_pkg::bcd_t           s6_min_q, s6_sec_q, s6_frm_q;

  always_comb begin
    s6_sec_unit = s5_sec_q - SECW'(s5_sec_ten_q) * SECW'(10);
    s6_sec_bcd  = {s5_sec_ten_q, s6_sec_unit[3:0]};
    s6_min_d    = s5_neg_q ? -s5_min_bcd_q : s5_min_bcd_q;
    s6_sec_d    = s5_neg_q ? -s6_sec_bcd   : s6_sec_bcd;
    s6_frm_d    = s5_neg_q ? -s5_frm_bcd_q : s5_frm_bcd_q;
    s6_val_d    = s5_val_q;
    case (s5_cmd_q)
      fcmb_pkg::CMD_DECODE: begin
        s6_min_d = '0;
        s6_sec_d = '0;
        s6_frm_d = '0;
      end
      default: begin
        s6_val_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load[5]) begin
      s6_val_q <= s6_val_d;
      s6_min_q <= s6_min_d;
      s6_sec_q <= s6_sec_d;
      s6_frm_q <= s6_frm_d;
    end
  end

  assign out_o.decoded_count  = s6_val_q;
  assign out_o.minute_bcd_out = s6_min_q;
  assign out_o.second_bcd_out = s6_sec_q;
  assign out_o.frame_bcd_out  = s6_frm_q;

endmodule

@@ bench/frame_count_msf_bcd_convert_core_tb.sv @@
// Testbench for the frame count <-> packed BCD MSF converter, checked against its own predictor.
`timescale 1ns / 1ps

module frame_count_msf_bcd_convert_core_tb;

  localparam int FRAMES_BIAS        = 150;
  localparam int FRAMES_PER_SECOND  = 75;
  localparam int SECONDS_PER_MINUTE = 60;
  localparam int PIPE_DEPTH         = 6;
  localparam int CYCLE_LIMIT        = 200000;

  typedef struct {
    fcmb_pkg::cmd_e         command;
    fcmb_pkg::frame_count_t frame_count;
    fcmb_pkg::bcd_t         minute_bcd;
    fcmb_pkg::bcd_t         second_bcd;
    fcmb_pkg::bcd_t         frame_bcd;
  } addr_req_t;

  typedef struct {
    fcmb_pkg::decoded_count_t decoded_count;
    fcmb_pkg::bcd_t           minute_bcd;
    fcmb_pkg::bcd_t           second_bcd;
    fcmb_pkg::bcd_t           frame_bcd;
  } addr_res_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fcmb_in_if  in_ch ();
  fcmb_out_if out_ch ();

  frame_count_msf_bcd_convert_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  addr_res_t pending_addr_results[$];
  int        fail_cnt       = 0;
  int        cycle_cnt      = 0;
  int        src_idle_pct   = 0;
  int        snk_idle_pct   = 0;
  int        src_burst_left = 0;
  int        snk_burst_left = 0;

  always #5 clk_i = ~clk_i;

  // Truncating division, so negative values give the same wrapped bytes as the block.
  function automatic fcmb_pkg::bcd_t to_bcd_byte(input int v);
    int tens;
    tens = v / 10;
    return fcmb_pkg::bcd_t'(tens * 16 + (v - tens * 10));
  endfunction

  function automatic int from_bcd_byte(input fcmb_pkg::bcd_t b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  function automatic addr_res_t convert_frame_addr(input addr_req_t r);
    addr_res_t res;
    int        biased;
    int        total_sec;
    int        frames;
    int        minutes;
    int        seconds;
    res = '{decoded_count: '0, minute_bcd: '0, second_bcd: '0, frame_bcd: '0};
    if (r.command == fcmb_pkg::CMD_ENCODE) begin
      biased         = int'(r.frame_count) + FRAMES_BIAS;
      total_sec      = biased / FRAMES_PER_SECOND;
      frames         = biased - total_sec * FRAMES_PER_SECOND;
      minutes        = total_sec / SECONDS_PER_MINUTE;
      seconds        = total_sec - minutes * SECONDS_PER_MINUTE;
      res.minute_bcd = to_bcd_byte(minutes);
      res.second_bcd = to_bcd_byte(seconds);
      res.frame_bcd  = to_bcd_byte(frames);
    end else begin
      res.decoded_count = fcmb_pkg::decoded_count_t'(
        FRAMES_PER_SECOND * (SECONDS_PER_MINUTE * from_bcd_byte(r.minute_bcd)
                             + from_bcd_byte(r.second_bcd))
        + from_bcd_byte(r.frame_bcd) - FRAMES_BIAS);
    end
    return res;
  endfunction

  // Fill the fields the command ignores with noise.
  function automatic addr_req_t encode_req(input int count);
    addr_req_t r;
    r.command     = fcmb_pkg::CMD_ENCODE;
    r.frame_count = fcmb_pkg::frame_count_t'(count);
    r.minute_bcd  = fcmb_pkg::bcd_t'($urandom);
    r.second_bcd  = fcmb_pkg::bcd_t'($urandom);
    r.frame_bcd   = fcmb_pkg::bcd_t'($urandom);
    return r;
  endfunction

  function automatic addr_req_t decode_req(input fcmb_pkg::bcd_t m, input fcmb_pkg::bcd_t s,
                                           input fcmb_pkg::bcd_t f);
    addr_req_t r;
    r.command     = fcmb_pkg::CMD_DECODE;
    r.frame_count = fcmb_pkg::frame_count_t'($urandom);
    r.minute_bcd  = m;
    r.second_bcd  = s;
    r.frame_bcd   = f;
    return r;
  endfunction

  function automatic addr_req_t random_encode_req();
    if ($urandom_range(0, 99) < 85) begin
      return encode_req(int'($urandom_range(0, 449999)) - FRAMES_BIAS);
    end
    return encode_req(int'($urandom));
  endfunction

  function automatic addr_req_t random_decode_req();
    if ($urandom_range(0, 99) < 80) begin
      return decode_req(to_bcd_byte($urandom_range(0, 99)), to_bcd_byte($urandom_range(0, 59)),
                        to_bcd_byte($urandom_range(0, 74)));
    end
    return decode_req(fcmb_pkg::bcd_t'($urandom), fcmb_pkg::bcd_t'($urandom),
                      fcmb_pkg::bcd_t'($urandom));
  endfunction

  function automatic void check_field(input string name, input logic [20:0] want,
                                      input logic [20:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input addr_req_t r);
    if (src_burst_left == 0 && $urandom_range(0, 99) < 2) begin
      src_burst_left = $urandom_range(10, 40);
    end
    if (src_burst_left > 0) begin
      src_burst_left--;
    end else begin
      while ($urandom_range(0, 99) < src_idle_pct) begin
        in_ch.valid = 1'b0;
        @(negedge clk_i);
      end
    end
    in_ch.valid         = 1'b1;
    in_ch.command       = r.command;
    in_ch.frame_count   = r.frame_count;
    in_ch.minute_bcd_in = r.minute_bcd;
    in_ch.second_bcd_in = r.second_bcd;
    in_ch.frame_bcd_in  = r.frame_bcd;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_addr_results.push_back(convert_frame_addr(r));
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    in_ch.valid = 1'b0;
    while (pending_addr_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_directed_corners();
    int enc_counts[11] = '{-150, -151, -1, 0, -76, -75, 4350, 449849, 449850,
                           -524288, 524287};
    foreach (enc_counts[i]) send_item(encode_req(enc_counts[i]));
    send_item(decode_req(8'h00, 8'h00, 8'h00));
    send_item(decode_req(8'h00, 8'h02, 8'h00));
    send_item(decode_req(8'h99, 8'h59, 8'h74));
    // non-decimal nibbles at face value, up to the largest count
    send_item(decode_req(8'hFF, 8'hFF, 8'hFF));
    send_item(decode_req(8'hA0, 8'h00, 8'h00));
    send_item(decode_req(8'h0F, 8'h0F, 8'h0F));
    send_item(decode_req(8'hF0, 8'hF0, 8'hF0));
    send_item(decode_req(8'h59, 8'h00, 8'h01));
    send_item(decode_req(8'h00, 8'h00, 8'h74));
  endtask

  task automatic test_encode_sweep(input int n);
    repeat (n) send_item(random_encode_req());
  endtask

  task automatic test_decode_sweep(input int n);
    repeat (n) send_item(random_decode_req());
  endtask

  task automatic test_mixed_stream(input int n);
    for (int i = 0; i < n; i++) begin
      // hold the sender until the pipe is empty once midway
      if (i == n / 2) wait_results_drained();
      if ($urandom_range(0, 1) == 0) begin
        send_item(random_encode_req());
      end else begin
        send_item(random_decode_req());
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (snk_burst_left == 0 && $urandom_range(0, 99) < 2) begin
      snk_burst_left = $urandom_range(10, 40);
    end
    if (snk_burst_left > 0) begin
      snk_burst_left--;
      out_ch.ready = 1'b1;
    end else begin
      out_ch.ready = ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    addr_res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_addr_results.size() == 0) begin
        $display("%0t: result item with none expected, expected none actual %h %h %h %h",
                 $time, out_ch.decoded_count, out_ch.minute_bcd_out, out_ch.second_bcd_out,
                 out_ch.frame_bcd_out);
        fail_cnt++;
      end else begin
        want = pending_addr_results.pop_front();
        check_field("decoded_count", want.decoded_count, out_ch.decoded_count);
        check_field("minute_bcd_out", 21'(want.minute_bcd), 21'(out_ch.minute_bcd_out));
        check_field("second_bcd_out", 21'(want.second_bcd), 21'(out_ch.second_bcd_out));
        check_field("frame_bcd_out", 21'(want.frame_bcd), 21'(out_ch.frame_bcd_out));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.command       = fcmb_pkg::CMD_ENCODE;
    in_ch.frame_count   = '0;
    in_ch.minute_bcd_in = '0;
    in_ch.second_bcd_in = '0;
    in_ch.frame_bcd_in  = '0;
    out_ch.ready        = 1'b0;
    rst_ni              = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    src_idle_pct = 37;
    snk_idle_pct = 81;
    test_directed_corners();
    test_encode_sweep(450);
    wait_results_drained();

    src_idle_pct = 81;
    snk_idle_pct = 37;
    test_decode_sweep(450);
    wait_results_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_mixed_stream(500);
    wait_results_drained();

    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/fcmb_pkg.sv
rtl/fcmb_in_if.sv
rtl/fcmb_out_if.sv
rtl/frame_count_msf_bcd_convert_core.sv
bench/frame_count_msf_bcd_convert_core_tb.sv
